@@ rtl/ppm_frame_decoder_top_assert.svh @@
// Assertion macros for the PPM frame decoder top level.
`ifndef PPM_FRAME_DECODER_TOP_ASSERT_SVH
`define PPM_FRAME_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPMFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppmfd: check failed");
`define PPMFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppmfd: check failed");
`else
`define PPMFD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPMFD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ppmfd_pkg.sv @@
// Shared types and constants of the PPM frame decoder.
`timescale 1ns / 1ps
package ppmfd_pkg;
    localparam int unsigned TimeW       = 32;
    localparam int unsigned WidthW      = 16;
    localparam int unsigned CntW        = 5;
    localparam int unsigned IdxW        = 4;
    localparam int unsigned FrameW      = 8;
    localparam int unsigned CfgIdxW     = 3;
    localparam int unsigned CfgDataW    = 16;
    localparam int unsigned MinChannels = 4;

    localparam logic [CntW-1:0] NoneCode = 5'd31;

    localparam logic REQ_EDGE     = 1'b0;
    localparam logic REQ_OVERFLOW = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_COUNT_SHIFT   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SYNC_MIN      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PULSE_MIN     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PULSE_MAX     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_STABLE_NEEDED = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_VALUE = 3'd5;

    typedef struct packed {
        logic [1:0]        count_shift;
        logic [WidthW-1:0] sync_min;
        logic [WidthW-1:0] pulse_min;
        logic [WidthW-1:0] pulse_max;
        logic [CntW-1:0]   stable_needed;
        logic [WidthW-1:0] timeout_value;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        count_shift:   2'd0,
        sync_min:      16'd2700,
        pulse_min:     16'd750,
        pulse_max:     16'd2250,
        stable_needed: 5'd25,
        timeout_value: 16'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DECIDE,
        ST_PUB_RD,
        ST_PUB_WR
    } t_state;

    typedef struct packed {
        logic idle;
        logic publishing;
        logic store_we;
    } t_status;
endpackage

@@ rtl/ppmfd_if.sv @@
// Valid/ready channel interfaces for event items and channel result items.
`timescale 1ns / 1ps
interface ppmfd_in_if import ppmfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [WidthW-1:0] capture_value;

    modport source (output valid, output req_type, output capture_value, input ready);
    modport sink   (input valid, input req_type, input capture_value, output ready);
endinterface

interface ppmfd_out_if import ppmfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IdxW-1:0]   channel_index;
    logic [WidthW-1:0] channel_width;
    logic [FrameW-1:0] frame_number;
    logic              last_of_frame;

    modport source (output valid, output channel_index, output channel_width,
                    output frame_number, output last_of_frame, input ready);
    modport sink   (input valid, input channel_index, input channel_width,
                    input frame_number, input last_of_frame, output ready);
endinterface

@@ rtl/ppmfd_cfg.sv @@
// Configuration register bank of the PPM frame decoder.
`timescale 1ns / 1ps
module ppmfd_cfg import ppmfd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);
    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COUNT_SHIFT:   n_cfg.count_shift   = i_cfg_data[1:0];
                CFG_SYNC_MIN:      n_cfg.sync_min      = i_cfg_data;
                CFG_PULSE_MIN:     n_cfg.pulse_min     = i_cfg_data;
                CFG_PULSE_MAX:     n_cfg.pulse_max     = i_cfg_data;
                CFG_STABLE_NEEDED: n_cfg.stable_needed = i_cfg_data[CntW-1:0];
                CFG_TIMEOUT_VALUE: n_cfg.timeout_value = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ rtl/ppmfd_store.sv @@
// Pulse width store: one write port, one registered read port.
`timescale 1ns / 1ps
module ppmfd_store import ppmfd_pkg::*; #(
    parameter int unsigned DEPTH = 12,
    parameter int unsigned AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WidthW-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [WidthW-1:0] o_rdata
);
    logic [WidthW-1:0] r_mem [DEPTH];
    logic [WidthW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/ppmfd_ctrl.sv @@
// Event sequencer: time base, frame tracking, lock logic and slot publishing.
`timescale 1ns / 1ps
module ppmfd_ctrl import ppmfd_pkg::*; #(
    parameter int unsigned MAX_CHANNELS = 12,
    parameter int unsigned AW           = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    ppmfd_in_if.sink            i_req,
    ppmfd_out_if.source         o_rsp,
    output logic                o_store_we,
    output logic [AW-1:0]       o_store_waddr,
    output logic [WidthW-1:0]   o_store_wdata,
    output logic                o_store_re,
    output logic [AW-1:0]       o_store_raddr,
    input  logic [WidthW-1:0]   i_store_rdata,
    output t_status             o_status
);
    t_state            r_state,      n_state;
    logic [TimeW-1:0]  r_ext,        n_ext;
    logic [TimeW-1:0]  r_now,        n_now;
    logic [TimeW-1:0]  r_delta,      n_delta;
    logic [TimeW-1:0]  r_prev,       n_prev;
    logic [CntW-1:0]   r_pc,         n_pc;
    logic [CntW-1:0]   r_locked,     n_locked;
    logic [CntW-1:0]   r_prev_frame, n_prev_frame;
    logic [CntW-1:0]   r_stable,     n_stable;
    logic              r_tracking,   n_tracking;
    logic [FrameW-1:0] r_frame,      n_frame;
    logic [AW-1:0]     r_idx,        n_idx;
    logic              r_out_valid,  n_out_valid;
    logic [IdxW-1:0]   r_out_index,  n_out_index;
    logic [WidthW-1:0] r_out_width,  n_out_width;
    logic [FrameW-1:0] r_out_frame,  n_out_frame;
    logic              r_out_last,   n_out_last;

    logic [TimeW-1:0]  w_sum;
    logic [TimeW-1:0]  w_stamp;
    logic              w_hi_zero;
    logic [WidthW-1:0] w_lo;
    logic              w_gap;
    logic              w_qual;
    logic [CntW-1:0]   w_lock_next;
    logic              w_publish;
    logic              w_pulse_ok;
    logic              w_out_free;
    logic              w_last_slot;

    assign w_sum     = r_ext + TimeW'(i_req.capture_value);
    assign w_stamp   = w_sum >> i_cfg.count_shift;
    assign w_hi_zero = (r_delta[TimeW-1:WidthW] == '0);
    assign w_lo      = r_delta[WidthW-1:0];
    assign w_gap     = !w_hi_zero || (w_lo > i_cfg.sync_min);
    assign w_qual    = (r_pc == r_prev_frame) && (r_pc >= CntW'(MinChannels))
                       && (r_pc <= CntW'(MAX_CHANNELS));
    assign w_lock_next = (w_qual && !(r_stable < i_cfg.stable_needed)) ? r_pc : r_locked;
    assign w_publish   = (r_pc == w_lock_next) && r_tracking;
    assign w_pulse_ok  = (!w_hi_zero || (w_lo > i_cfg.pulse_min)) && w_hi_zero
                         && (w_lo < i_cfg.pulse_max) && (r_pc < CntW'(MAX_CHANNELS));
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_last_slot = (r_idx == AW'(MAX_CHANNELS - 1));

    assign o_store_we    = (r_state == ST_DECIDE) && !w_gap && r_tracking && w_pulse_ok;
    assign o_store_waddr = r_pc[AW-1:0];
    assign o_store_wdata = w_lo;
    assign o_store_re    = (r_state == ST_PUB_RD);
    assign o_store_raddr = r_idx;

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.channel_index = r_out_index;
    assign o_rsp.channel_width = r_out_width;
    assign o_rsp.frame_number  = r_out_frame;
    assign o_rsp.last_of_frame = r_out_last;

    assign o_status.idle       = (r_state == ST_IDLE);
    assign o_status.publishing = (r_state == ST_PUB_RD) || (r_state == ST_PUB_WR);
    assign o_status.store_we   = o_store_we;

    always_comb begin
        n_state      = r_state;
        n_ext        = r_ext;
        n_now        = r_now;
        n_delta      = r_delta;
        n_prev       = r_prev;
        n_pc         = r_pc;
        n_locked     = r_locked;
        n_prev_frame = r_prev_frame;
        n_stable     = r_stable;
        n_tracking   = r_tracking;
        n_frame      = r_frame;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_index  = r_out_index;
        n_out_width  = r_out_width;
        n_out_frame  = r_out_frame;
        n_out_last   = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_OVERFLOW) begin
                        n_ext = w_sum + TimeW'(1);
                    end else begin
                        n_now   = w_stamp;
                        n_state = ST_DELTA;
                    end
                end
            end
            ST_DELTA: begin
                n_delta = r_now - r_prev;
                n_prev  = r_now;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = ST_IDLE;
                if (w_gap) begin
                    if (w_qual) begin
                        if (r_stable < i_cfg.stable_needed) begin
                            n_stable = r_stable + CntW'(1);
                        end
                    end else begin
                        n_stable = '0;
                    end
                    n_locked     = w_lock_next;
                    n_tracking   = 1'b1;
                    n_prev_frame = r_pc;
                    n_pc         = '0;
                    if (w_publish) begin
                        n_frame = r_frame + FrameW'(1);
                        n_idx   = '0;
                        n_state = ST_PUB_RD;
                    end
                end else if (r_tracking) begin
                    if (w_pulse_ok) begin
                        n_pc = r_pc + CntW'(1);
                    end else begin
                        n_tracking = 1'b0;
                    end
                end
            end
            ST_PUB_RD: begin
                n_state = ST_PUB_WR;
            end
            ST_PUB_WR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = IdxW'(r_idx);
                    n_out_width = (CntW'(r_idx) < r_locked) ? i_store_rdata
                                                            : i_cfg.timeout_value;
                    n_out_frame = r_frame;
                    n_out_last  = w_last_slot;
                    if (w_last_slot) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ST_PUB_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ext        <= '0;
            r_prev       <= '0;
            r_pc         <= '0;
            r_locked     <= NoneCode;
            r_prev_frame <= NoneCode;
            r_stable     <= '0;
            r_tracking   <= 1'b0;
            r_frame      <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ext        <= n_ext;
            r_prev       <= n_prev;
            r_pc         <= n_pc;
            r_locked     <= n_locked;
            r_prev_frame <= n_prev_frame;
            r_stable     <= n_stable;
            r_tracking   <= n_tracking;
            r_frame      <= n_frame;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_delta     <= n_delta;
        r_out_index <= n_out_index;
        r_out_width <= n_out_width;
        r_out_frame <= n_out_frame;
        r_out_last  <= n_out_last;
    end
endmodule

@@ rtl/ppm_frame_decoder_top.sv @@
// Top level of the PPM frame decoder.
// The decoder takes timer overflow and capture edge items and, for every
// well-formed frame once the channel count is locked, emits MAX_CHANNELS
// channel items with the frame number. An edge item passes through the
// timestamp, interval and decision steps. An edge that closes a published
// frame then has every slot published: the pulse store has one read port
// with a registered read, so each slot is read and then moved to the output
// register, and back-pressure on the output stalls this. The output register
// lets the next item in while the last slot waits.
`timescale 1ns / 1ps
`include "ppm_frame_decoder_top_assert.svh"
module ppm_frame_decoder_top import ppmfd_pkg::*; #(
    parameter int unsigned MAX_CHANNELS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    ppmfd_in_if.sink            i_req,
    ppmfd_out_if.source         o_rsp
);
    localparam int unsigned AW = $clog2(MAX_CHANNELS);

    t_cfg              w_cfg;
    t_status           w_status;
    logic              w_store_we;
    logic [AW-1:0]     w_store_waddr;
    logic [WidthW-1:0] w_store_wdata;
    logic              w_store_re;
    logic [AW-1:0]     w_store_raddr;
    logic [WidthW-1:0] w_store_rdata;

    ppmfd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ppmfd_store #(
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (w_store_waddr),
        .i_wdata (w_store_wdata),
        .i_re    (w_store_re),
        .i_raddr (w_store_raddr),
        .o_rdata (w_store_rdata)
    );

    ppmfd_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_store_we    (w_store_we),
        .o_store_waddr (w_store_waddr),
        .o_store_wdata (w_store_wdata),
        .o_store_re    (w_store_re),
        .o_store_raddr (w_store_raddr),
        .i_store_rdata (w_store_rdata),
        .o_status      (w_status)
    );

    `PPMFD_ASSERT_IMP(a_last_slot_index, i_clk, i_rst_n, o_rsp.valid && o_rsp.last_of_frame, o_rsp.channel_index == IdxW'(MAX_CHANNELS - 1))
    `PPMFD_ASSERT_IMP(a_no_accept_publish, i_clk, i_rst_n, w_status.publishing, !i_req.ready)
    `PPMFD_ASSERT_IMP(a_no_write_publish, i_clk, i_rst_n, w_status.store_we, !w_status.publishing && !w_status.idle)
    `PPMFD_ASSERT_NXT(a_edge_busy, i_clk, i_rst_n, i_req.valid && i_req.ready && (i_req.req_type == REQ_EDGE), !i_req.ready)
endmodule

@@ test/ppm_frame_decoder_checker.sv @@
// Checker for the PPM frame decoder: models the decoder and compares its channel items.
`timescale 1ns / 1ps
module ppm_frame_decoder_checker import ppmfd_pkg::*; #(
    parameter int unsigned MAX_CH = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    ppmfd_in_if                 i_req,
    ppmfd_out_if                i_rsp,
    output int unsigned         o_pending,
    output int unsigned         o_fail_count
);
    typedef struct packed {
        logic [IdxW-1:0]   chan;
        logic [WidthW-1:0] width;
        logic [FrameW-1:0] frame;
        logic              is_last;
    } t_slot;

    t_slot             expected_slots[$];
    t_cfg              regs;
    logic [TimeW-1:0]  ext_time;
    logic [TimeW-1:0]  last_stamp;
    logic [CntW-1:0]   pulses;
    logic [CntW-1:0]   lock_len;
    logic [CntW-1:0]   prev_len;
    logic [CntW-1:0]   stable;
    logic              tracking;
    logic [FrameW-1:0] frame_cnt;
    logic [WidthW-1:0] widths[MAX_CH];
    int unsigned       mismatches = 0;

    task automatic decode_event(input logic kind, input logic [WidthW-1:0] cap);
        logic [TimeW-1:0] stamp;
        logic [TimeW-1:0] gap;
        t_slot            s;
        if (kind == REQ_OVERFLOW) begin
            ext_time = ext_time + TimeW'(cap) + 1;
            return;
        end
        stamp = (TimeW'(cap) + ext_time) >> regs.count_shift;
        gap = stamp - last_stamp;
        last_stamp = stamp;
        if (gap > TimeW'(regs.sync_min)) begin
            if (pulses == prev_len && pulses >= MinChannels && pulses <= MAX_CH) begin
                if (stable < regs.stable_needed) begin
                    stable = stable + 1'b1;
                end else begin
                    lock_len = pulses;
                end
            end else begin
                stable = '0;
            end
            if (pulses == lock_len && tracking) begin
                frame_cnt = frame_cnt + 1'b1;
                for (int i = 0; i < MAX_CH; i++) begin
                    s.chan    = IdxW'(i);
                    s.width   = (i < lock_len) ? widths[i] : regs.timeout_value;
                    s.frame   = frame_cnt;
                    s.is_last = (i == MAX_CH - 1);
                    expected_slots.push_back(s);
                end
            end
            tracking = 1'b1;
            prev_len = pulses;
            pulses = '0;
        end else if (tracking) begin
            if (gap > TimeW'(regs.pulse_min) && gap < TimeW'(regs.pulse_max)
                && pulses < MAX_CH) begin
                widths[pulses] = gap[WidthW-1:0];
                pulses = pulses + 1'b1;
            end else begin
                tracking = 1'b0;
                foreach (widths[i]) widths[i] = regs.timeout_value;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [WidthW-1:0] want,
                               input logic [WidthW-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_slot want;
        if (!i_rst_n) begin
            expected_slots.delete();
            regs       = CfgReset;
            ext_time   = '0;
            last_stamp = '0;
            pulses     = '0;
            lock_len   = NoneCode;
            prev_len   = NoneCode;
            stable     = '0;
            tracking   = 1'b0;
            frame_cnt  = '0;
            foreach (widths[i]) widths[i] = '0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_slots.size() == 0) begin
                    $error("unexpected channel item: channel_index %0d, channel_width %0d",
                           i_rsp.channel_index, i_rsp.channel_width);
                    mismatches++;
                end else begin
                    want = expected_slots.pop_front();
                    check_field("channel_index", want.chan, i_rsp.channel_index);
                    check_field("channel_width", want.width, i_rsp.channel_width);
                    check_field("frame_number", want.frame, i_rsp.frame_number);
                    check_field("last_of_frame", want.is_last, i_rsp.last_of_frame);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COUNT_SHIFT:   regs.count_shift   = i_cfg_data[1:0];
                    CFG_SYNC_MIN:      regs.sync_min      = i_cfg_data;
                    CFG_PULSE_MIN:     regs.pulse_min     = i_cfg_data;
                    CFG_PULSE_MAX:     regs.pulse_max     = i_cfg_data;
                    CFG_STABLE_NEEDED: regs.stable_needed = i_cfg_data[CntW-1:0];
                    CFG_TIMEOUT_VALUE: regs.timeout_value = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                decode_event(i_req.req_type, i_req.capture_value);
            end
        end
        o_pending    <= expected_slots.size();
        o_fail_count <= mismatches;
    end
endmodule

@@ test/ppm_frame_decoder_top_tb.sv @@
// Testbench top for the PPM frame decoder: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module ppm_frame_decoder_top_tb;
    import ppmfd_pkg::*;

    localparam int unsigned MAX_CH      = 12;
    localparam int          SETTLE      = 4 * MAX_CH + 8;
    localparam int          HOLD_CYCLES = 400;
    localparam int          STALL_LIMIT = 3000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;
    int unsigned         pending;
    int unsigned         fail_total;
    int unsigned         rsp_seen = 0;
    int                  stall_cycles = 0;
    bit                  hold_req = 1'b0;
    t_cfg                cur_cfg = CfgReset;
    logic [TimeW-1:0]    ext_acc = '0;
    logic [TimeW-1:0]    raw_prev = '0;

    ppmfd_in_if  req_ch ();
    ppmfd_out_if rsp_ch ();

    ppm_frame_decoder_top #(.MAX_CHANNELS(MAX_CH)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    ppm_frame_decoder_checker #(.MAX_CH(MAX_CH)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_pending    (pending),
        .o_fail_count (fail_total)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen <= rsp_seen + 1;
        end
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ppm_frame_decoder_top verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pulse_width();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return int'(cur_cfg.pulse_min) + 1;
        if (r == 1) return int'(cur_cfg.pulse_max) - 1;
        return $urandom_range(int'(cur_cfg.pulse_min) + 1, int'(cur_cfg.pulse_max) - 1);
    endfunction

    function automatic int unsigned bad_width();
        if (cur_cfg.pulse_max <= cur_cfg.sync_min && $urandom_range(0, 1) == 1) begin
            return cur_cfg.pulse_max;
        end
        return $urandom_range(0, int'(cur_cfg.pulse_min));
    endfunction

    initial begin : rsp_pacer
        int run;
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 6);
                @(posedge i_clk);
                for (int k = 1; k < run && !hold_req; k++) @(posedge i_clk);
                gap = gap_len();
                if (gap > 0 && !hold_req) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    task automatic push_event(input logic kind, input logic [WidthW-1:0] value);
        int idle;
        idle = gap_len();
        if (idle > 0) begin
            req_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.capture_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        if (kind == REQ_OVERFLOW) begin
            ext_acc = ext_acc + value + 1;
        end else begin
            raw_prev = ext_acc + value;
        end
    endtask

    // Place an edge d timestamp units after the previous one, extending the time base as needed.
    task automatic edge_after(input int unsigned d);
        logic [TimeW-1:0] target;
        logic [TimeW-1:0] room;
        target = raw_prev + (d << cur_cfg.count_shift);
        room = target - ext_acc;
        if (room[TimeW-1]) begin
            target = ext_acc + $urandom_range(0, 255);
        end
        while (target - ext_acc > 32'd65535) begin
            push_event(REQ_OVERFLOW, ($urandom_range(0, 3) == 0) ? WidthW'($urandom_range(0, 65535))
                                                                 : 16'hFFFF);
        end
        if (target != ext_acc && $urandom_range(0, 5) == 0) begin
            room = target - ext_acc - 1;
            push_event(REQ_OVERFLOW, WidthW'($urandom_range(0, room)));
        end
        push_event(REQ_EDGE, WidthW'(target - ext_acc));
    endtask

    task automatic send_frame(input int len, input int bad_at);
        edge_after(int'(cur_cfg.sync_min) + 1 + $urandom_range(0, 4000));
        for (int k = 1; k <= len; k++) begin
            edge_after((k == bad_at) ? bad_width() : pulse_width());
        end
    endtask

    task automatic send_noise(input int count);
        for (int k = 0; k < count; k++) begin
            push_event($urandom_range(0, 1) ? REQ_OVERFLOW : REQ_EDGE,
                       WidthW'($urandom_range(0, 65535)));
        end
    endtask

    task automatic run_frames(input int n, input int len);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) send_noise($urandom_range(1, 3));
            if (r == 1) begin
                send_frame($urandom_range(1, 13), 0);
            end else if (r == 2) begin
                send_frame(len, $urandom_range(1, len));
            end else begin
                send_frame(len, 0);
            end
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic poke(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        poke(CFG_COUNT_SHIFT, CfgDataW'(c.count_shift));
        poke(CFG_SYNC_MIN, c.sync_min);
        poke(CFG_PULSE_MIN, c.pulse_min);
        poke(CFG_PULSE_MAX, c.pulse_max);
        poke(CFG_STABLE_NEEDED, CfgDataW'(c.stable_needed));
        poke(CFG_TIMEOUT_VALUE, c.timeout_value);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_cfg = c;
    endtask

    initial begin
        t_cfg c;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_COUNT_SHIFT;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_EDGE;
        req_ch.capture_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_event(REQ_OVERFLOW, 16'hFFFF);
        push_event(REQ_OVERFLOW, 16'h0000);
        push_event(REQ_EDGE, 16'hFFFF);
        push_event(REQ_EDGE, 16'h0000);
        edge_after(int'(cur_cfg.pulse_min) + 1);
        edge_after(int'(cur_cfg.pulse_max) - 1);
        edge_after(1500);
        edge_after(1000);
        edge_after(int'(cur_cfg.sync_min) + 1);
        edge_after(cur_cfg.pulse_max);
        edge_after(1000);
        edge_after(cur_cfg.sync_min);
        edge_after(int'(cur_cfg.sync_min) + 1);
        edge_after(cur_cfg.pulse_min);
        edge_after(int'(cur_cfg.sync_min) + 1);
        edge_after(0);

        c = CfgReset;
        c.stable_needed = '0;
        c.timeout_value = WidthW'($urandom_range(0, 65535));
        load_cfg(c);
        run_frames(2, 5);
        send_frame(13, 0);
        hold_req = 1'b1;
        run_frames(3, 5);
        wait_drained();

        c.count_shift   = 2'd3;
        c.sync_min      = 16'd3000;
        c.pulse_min     = 16'd0;
        c.pulse_max     = 16'd3001;
        c.stable_needed = 5'd2;
        c.timeout_value = 16'hFFFF;
        load_cfg(c);
        run_frames(6, 4);

        c.count_shift   = 2'd2;
        c.sync_min      = 16'd0;
        c.pulse_min     = 16'hFFFF;
        c.pulse_max     = 16'd0;
        c.stable_needed = 5'd31;
        c.timeout_value = WidthW'($urandom_range(0, 65535));
        load_cfg(c);
        send_noise(15);

        c.count_shift   = 2'd1;
        c.sync_min      = 16'hFFFF;
        c.pulse_min     = 16'd0;
        c.pulse_max     = 16'hFFFF;
        c.stable_needed = 5'd31;
        c.timeout_value = 16'd0;
        load_cfg(c);
        run_frames(2, 4);

        c = CfgReset;
        c.stable_needed = 5'd1;
        c.timeout_value = WidthW'($urandom_range(0, 65535));
        load_cfg(c);
        run_frames(4, 6);
        for (int k = 0; k < 4 && rsp_seen < 60; k++) send_frame(6, 0);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_total == 0) begin
            $display("ppm_frame_decoder_top verification clean");
        end else begin
            $display("ppm_frame_decoder_top verification failed");
        end
        $finish;
    end
endmodule
